// ===== rtl/core/ogmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogmm_pkg
// Shared types, widths and codes of the occupancy grid min-merge core.
// ----------------------------------------------------------------------------
package ogmm_pkg;

    // Grid limits and coordinate format
    localparam int MAX_WIDTH_DEF   = 256;
    localparam int MAX_HEIGHT_DEF  = 256;
    localparam int COORD_FRAC_BITS = 16;

    // Fixed field widths
    localparam int ORG_W  = 32;                 // Q16.16 origin
    localparam int IDX_W  = 12;                 // source column / row
    localparam int CS_W   = 31;                 // cell size
    localparam int GRID_W = 9;                  // grid_width / grid_height registers
    localparam int SIZE_W = 13;                 // effective size, holds up to 4096
    localparam int PROD_W = SIZE_W + CS_W;      // product of size or index by cell size
    localparam int DW     = 46;                 // signed datapath of the axis unit
    localparam int CELL_W = 8;

    // Reset cell size: 0.05 m in the coordinate format, rounded
    localparam logic [CS_W-1:0] CELL_SIZE_RESET =
        CS_W'(((64'd1 << COORD_FRAC_BITS) + 64'd10) / 64'd20);

    // Cell values
    localparam logic signed [CELL_W-1:0] UNKNOWN_CELL = -8'sd1;
    localparam logic signed [CELL_W-1:0] CELL_MAX     = 8'sd100;

    // Request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_MERGE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_MERGED_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_MERGED_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE       = 3'd2;
    localparam logic [2:0] REG_GRID_WIDTH      = 3'd3;
    localparam logic [2:0] REG_GRID_HEIGHT     = 3'd4;

    // Status of one axis mapping pass
    typedef struct packed {
        logic done;       // one-cycle pulse at the end of the pass
        logic in_range;   // coordinate lies inside [0, size) cells
    } map_status_t;

    // Bits needed to address n entries, at least one
    function automatic int addr_bits(int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== rtl/core/ogmm_axis_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogmm_axis_map
// Maps one world coordinate to a merged grid index. A shared multiplier and
// one add/subtract unit are sequenced through offset, bound check and a
// restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ogmm_axis_map #(
    parameter int QW = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ogmm_pkg::ORG_W-1:0]   origin,
    input  logic        [ogmm_pkg::IDX_W-1:0]   idx,
    input  logic signed [ogmm_pkg::ORG_W-1:0]   merged_org,
    input  logic        [ogmm_pkg::SIZE_W-1:0]  size,
    input  logic        [ogmm_pkg::CS_W-1:0]    cs,
    output ogmm_pkg::map_status_t               status,
    output logic        [QW-1:0]                quot
);

    localparam int DW     = ogmm_pkg::DW;
    localparam int PROD_W = ogmm_pkg::PROD_W;
    localparam int ORG_W  = ogmm_pkg::ORG_W;
    localparam int CS_W   = ogmm_pkg::CS_W;
    localparam int SIZE_W = ogmm_pkg::SIZE_W;
    localparam int CNT_W  = ogmm_pkg::addr_bits(QW);

    localparam logic [2:0] M_IDLE     = 3'd0;
    localparam logic [2:0] M_MUL_IDX  = 3'd1;
    localparam logic [2:0] M_ADD      = 3'd2;
    localparam logic [2:0] M_SUB      = 3'd3;
    localparam logic [2:0] M_MUL_SIZE = 3'd4;
    localparam logic [2:0] M_CMP      = 3'd5;
    localparam logic [2:0] M_DIV      = 3'd6;

    logic [2:0]             state_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic signed [DW-1:0]   acc_reg;
    logic [DW-1:0]          div_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [QW-1:0]          quot_reg;
    logic                   done_reg;
    logic                   ok_reg;

    logic [SIZE_W-1:0]      mul_a;
    logic [PROD_W-1:0]      mul_y;
    logic signed [DW-1:0]   alu_a;
    logic signed [DW-1:0]   alu_b;
    logic                   alu_sub;
    logic signed [DW-1:0]   alu_y;
    logic                   div_last;

    // Shared multiplier: index or size times cell size
    assign mul_a = (state_reg == M_MUL_SIZE) ? size : SIZE_W'(idx);
    assign mul_y = PROD_W'(mul_a) * PROD_W'(cs);

    // Shared add/subtract unit, operands chosen by the sequencer
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (state_reg)
            M_ADD:
            begin
                alu_a   = {{(DW-ORG_W){origin[ORG_W-1]}}, origin};
                alu_b   = {{(DW-PROD_W){1'b0}}, prod_reg};
                alu_sub = 1'b0;
            end
            M_SUB:   alu_b = {{(DW-ORG_W){merged_org[ORG_W-1]}}, merged_org};
            M_CMP:   alu_b = {{(DW-PROD_W){1'b0}}, prod_reg};
            M_DIV:   alu_b = div_reg;
            default: alu_b = '0;
        endcase
    end

    assign alu_y    = alu_a + (alu_b ^ {DW{alu_sub}}) + DW'(alu_sub);
    assign div_last = (cnt_reg == CNT_W'(QW - 1));

    // Sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= M_MUL_IDX;
                    end
                end
                M_MUL_IDX:  state_reg <= M_ADD;
                M_ADD:      state_reg <= M_SUB;
                M_SUB:      state_reg <= M_MUL_SIZE;
                M_MUL_SIZE: state_reg <= M_CMP;
                M_CMP:
                begin
                    // in range when 0 <= offset < size * cell size
                    if (acc_reg[DW-1] || !alu_y[DW-1])
                    begin
                        ok_reg    <= 1'b0;
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= M_DIV;
                    end
                end
                M_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (div_last)
                    begin
                        ok_reg    <= 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    // Payload: product, accumulator / remainder, divisor, quotient
    always_ff @(posedge clk)
    begin
        if (state_reg == M_MUL_IDX || state_reg == M_MUL_SIZE)
        begin
            prod_reg <= mul_y;
        end
        if (state_reg == M_ADD || state_reg == M_SUB)
        begin
            acc_reg <= alu_y;
        end
        if (state_reg == M_CMP)
        begin
            div_reg  <= {{(DW-CS_W){1'b0}}, cs} << (QW - 1);
            quot_reg <= '0;
        end
        if (state_reg == M_DIV)
        begin
            // restoring step: keep the difference when it stays non-negative
            if (!alu_y[DW-1])
            begin
                acc_reg <= alu_y;
            end
            quot_reg <= (quot_reg << 1) | QW'(!alu_y[DW-1]);
            div_reg  <= div_reg >> 1;
        end
    end

    assign status.done     = done_reg;
    assign status.in_range = ok_reg;
    assign quot            = quot_reg;

endmodule

// ===== rtl/core/occupancy_grid_min_merge_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_min_merge_core
// Merged occupancy grid with minimum-value merge of source map cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream (s_tuser = request kind), one result per
//   request leaves on the m_ stream. Registers are written on the cfg channel
//   (always ready); the user must write them only while the core is idle,
//   which the core itself does not enforce.
//   Clear (kind 0): sweeps the cell memory one cell per cycle, then
//     returns -1,0,0.
//   Merge (kind 1): each axis runs through the shared axis unit: two
//     multiplies, offset, bound check and QW division steps, QW the wider of
//     the column and row index widths; memory read and compare/write follow.
//   Read (kind 2): a registered memory read, then the result.
//   The core takes one request at a time; s_tready is high only when idle.
//   The result sits in an output register, so the core goes idle and takes
//   the next request while the receiver stalls; only the following result
//   waits for that register to drain.
//   After reset the core runs the same clearing sweep with s_tready low,
//   so every cell reads as unknown.
// ----------------------------------------------------------------------------
module occupancy_grid_min_merge_core #(
    parameter int MAX_WIDTH  = ogmm_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ogmm_pkg::MAX_HEIGHT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    // request stream
    input  logic          s_tvalid,
    output logic          s_tready,
    // src_col[11:0], src_row[23:12], src_origin_x[55:24], src_origin_y[87:56],
    // cell_value[95:88], read_col[103:96], read_row[111:104]
    input  logic [111:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]    s_tuser,
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    // cell_out[7:0]
    output logic [7:0]    m_tdata,
    // in_bounds[0], updated[1]
    output logic [1:0]    m_tuser,
    // configuration write channel
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    localparam int ORG_W  = ogmm_pkg::ORG_W;
    localparam int IDX_W  = ogmm_pkg::IDX_W;
    localparam int CS_W   = ogmm_pkg::CS_W;
    localparam int GRID_W = ogmm_pkg::GRID_W;
    localparam int SIZE_W = ogmm_pkg::SIZE_W;
    localparam int CELL_W = ogmm_pkg::CELL_W;
    localparam int COL_W  = ogmm_pkg::addr_bits(MAX_WIDTH);
    localparam int ROW_W  = ogmm_pkg::addr_bits(MAX_HEIGHT);
    localparam int QW     = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = ogmm_pkg::addr_bits(DEPTH);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_START_X = 4'd2;
    localparam logic [3:0] ST_MAP_X   = 4'd3;
    localparam logic [3:0] ST_START_Y = 4'd4;
    localparam logic [3:0] ST_MAP_Y   = 4'd5;
    localparam logic [3:0] ST_MEM_RD  = 4'd6;
    localparam logic [3:0] ST_UPDATE  = 4'd7;
    localparam logic [3:0] ST_RESULT  = 4'd8;

    // configuration registers
    logic signed [ORG_W-1:0]  merged_origin_x_reg;
    logic signed [ORG_W-1:0]  merged_origin_y_reg;
    logic [CS_W-1:0]          cell_size_reg;
    logic [GRID_W-1:0]        grid_width_reg;
    logic [GRID_W-1:0]        grid_height_reg;

    // control
    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic                     clr_result_reg;
    logic                     out_valid_reg;

    // latched request
    logic [1:0]               req_reg;
    logic [IDX_W-1:0]         src_col_reg;
    logic [IDX_W-1:0]         src_row_reg;
    logic signed [ORG_W-1:0]  src_origin_x_reg;
    logic signed [ORG_W-1:0]  src_origin_y_reg;
    logic signed [CELL_W-1:0] cell_value_reg;
    logic [7:0]               read_col_reg;
    logic [7:0]               read_row_reg;

    // mapping results, pending result, output register
    logic [COL_W-1:0]         qx_reg;
    logic [ROW_W-1:0]         qy_reg;
    logic signed [CELL_W-1:0] res_cell_reg;
    logic                     res_inb_reg;
    logic                     res_upd_reg;
    logic [CELL_W-1:0]        out_cell_reg;
    logic                     out_inb_reg;
    logic                     out_upd_reg;

    // cell memory
    logic [CELL_W-1:0]        mem [DEPTH];
    logic signed [CELL_W-1:0] rd_data_reg;

    logic                     accept;
    logic                     out_load;
    logic                     clr_last;
    logic [SIZE_W-1:0]        eff_w;
    logic [SIZE_W-1:0]        eff_h;
    logic [CS_W-1:0]          eff_cs;
    logic                     axis_y;
    logic                     map_start;
    logic signed [ORG_W-1:0]  map_origin;
    logic [IDX_W-1:0]         map_idx;
    logic signed [ORG_W-1:0]  map_merged;
    logic [SIZE_W-1:0]        map_size;
    ogmm_pkg::map_status_t    map_status;
    logic [QW-1:0]            map_quot;
    logic [SIZE_W-1:0]        rd_col_ext;
    logic [SIZE_W-1:0]        rd_row_ext;
    logic                     read_inb;
    logic [COL_W-1:0]         tgt_col;
    logic [ROW_W-1:0]         tgt_row;
    logic [ADDR_W-1:0]        mem_addr;
    logic signed [CELL_W-1:0] new_val;
    logic                     merge_write;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [CELL_W-1:0]        mem_wdata;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_RESULT) && (!out_valid_reg || m_tready);
    assign clr_last  = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    // effective grid size and cell size
    assign eff_w  = (SIZE_W'(grid_width_reg) > SIZE_W'(MAX_WIDTH)) ?
                    SIZE_W'(MAX_WIDTH) : SIZE_W'(grid_width_reg);
    assign eff_h  = (SIZE_W'(grid_height_reg) > SIZE_W'(MAX_HEIGHT)) ?
                    SIZE_W'(MAX_HEIGHT) : SIZE_W'(grid_height_reg);
    assign eff_cs = (cell_size_reg == '0) ? CS_W'(1) : cell_size_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merged_origin_x_reg <= '0;
            merged_origin_y_reg <= '0;
            cell_size_reg       <= ogmm_pkg::CELL_SIZE_RESET;
            grid_width_reg      <= GRID_W'(256);
            grid_height_reg     <= GRID_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ogmm_pkg::REG_MERGED_ORIGIN_X: merged_origin_x_reg <= cfg_data;
                ogmm_pkg::REG_MERGED_ORIGIN_Y: merged_origin_y_reg <= cfg_data;
                ogmm_pkg::REG_CELL_SIZE:       cell_size_reg   <= cfg_data[CS_W-1:0];
                ogmm_pkg::REG_GRID_WIDTH:      grid_width_reg  <= cfg_data[GRID_W-1:0];
                ogmm_pkg::REG_GRID_HEIGHT:     grid_height_reg <= cfg_data[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // axis unit operands, x first then y
    assign axis_y     = (state_reg == ST_START_Y) || (state_reg == ST_MAP_Y);
    assign map_start  = (state_reg == ST_START_X) || (state_reg == ST_START_Y);
    assign map_origin = axis_y ? src_origin_y_reg : src_origin_x_reg;
    assign map_idx    = axis_y ? src_row_reg : src_col_reg;
    assign map_merged = axis_y ? merged_origin_y_reg : merged_origin_x_reg;
    assign map_size   = axis_y ? eff_h : eff_w;

    ogmm_axis_map #(
        .QW (QW)
    ) u_axis_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (map_start),
        .origin     (map_origin),
        .idx        (map_idx),
        .merged_org (map_merged),
        .size       (map_size),
        .cs         (eff_cs),
        .status     (map_status),
        .quot       (map_quot)
    );

    // target cell address
    assign rd_col_ext = SIZE_W'(read_col_reg);
    assign rd_row_ext = SIZE_W'(read_row_reg);
    assign read_inb   = (rd_col_ext < eff_w) && (rd_row_ext < eff_h);
    assign tgt_col    = (req_reg == ogmm_pkg::REQ_READ) ? rd_col_ext[COL_W-1:0] : qx_reg;
    assign tgt_row    = (req_reg == ogmm_pkg::REQ_READ) ? rd_row_ext[ROW_W-1:0] : qy_reg;
    assign mem_addr   = ADDR_W'(tgt_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tgt_col);

    // min-merge decision
    assign new_val     = (cell_value_reg > ogmm_pkg::CELL_MAX) ?
                         ogmm_pkg::CELL_MAX : cell_value_reg;
    assign merge_write = (req_reg == ogmm_pkg::REQ_MERGE) && !new_val[CELL_W-1] &&
                         ((rd_data_reg == ogmm_pkg::UNKNOWN_CELL) ||
                          (new_val < rd_data_reg));

    // memory write port: clearing sweep or merge update
    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_UPDATE) && merge_write);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : mem_addr;
    assign mem_wdata = (state_reg == ST_CLEAR) ? ogmm_pkg::UNKNOWN_CELL : new_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[mem_addr];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = clr_result_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser)
                        ogmm_pkg::REQ_CLEAR: state_next = ST_CLEAR;
                        ogmm_pkg::REQ_MERGE: state_next = ST_START_X;
                        ogmm_pkg::REQ_READ:  state_next = ST_MEM_RD;
                        default:             state_next = ST_RESULT;
                    endcase
                end
            end
            ST_START_X: state_next = ST_MAP_X;
            ST_MAP_X:
            begin
                if (map_status.done)
                begin
                    state_next = map_status.in_range ? ST_START_Y : ST_RESULT;
                end
            end
            ST_START_Y: state_next = ST_MAP_Y;
            ST_MAP_Y:
            begin
                if (map_status.done)
                begin
                    state_next = map_status.in_range ? ST_MEM_RD : ST_RESULT;
                end
            end
            ST_MEM_RD:  state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_result_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + ADDR_W'(1);
                if (clr_last)
                begin
                    clr_result_reg <= 1'b0;
                end
            end
            if (accept && (s_tuser == ogmm_pkg::REQ_CLEAR))
            begin
                clr_result_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request latch, mapping results and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg          <= s_tuser;
            src_col_reg      <= s_tdata[11:0];
            src_row_reg      <= s_tdata[23:12];
            src_origin_x_reg <= s_tdata[55:24];
            src_origin_y_reg <= s_tdata[87:56];
            cell_value_reg   <= s_tdata[95:88];
            read_col_reg     <= s_tdata[103:96];
            read_row_reg     <= s_tdata[111:104];
            // default result: unknown, out of bounds, not written
            res_cell_reg     <= ogmm_pkg::UNKNOWN_CELL;
            res_inb_reg      <= 1'b0;
            res_upd_reg      <= 1'b0;
        end
        if ((state_reg == ST_MAP_X) && map_status.done)
        begin
            qx_reg <= map_quot[COL_W-1:0];
        end
        if ((state_reg == ST_MAP_Y) && map_status.done)
        begin
            qy_reg <= map_quot[ROW_W-1:0];
        end
        if (state_reg == ST_UPDATE)
        begin
            if (req_reg == ogmm_pkg::REQ_MERGE)
            begin
                res_inb_reg  <= 1'b1;
                res_upd_reg  <= merge_write;
                res_cell_reg <= merge_write ? new_val : rd_data_reg;
            end
            else if (read_inb)
            begin
                res_inb_reg  <= 1'b1;
                res_cell_reg <= rd_data_reg;
            end
        end
        if (out_load)
        begin
            out_cell_reg <= res_cell_reg;
            out_inb_reg  <= res_inb_reg;
            out_upd_reg  <= res_upd_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_cell_reg;
    assign m_tuser  = {out_upd_reg, out_inb_reg};

`ifndef SYNTHESIS
    // one request at a time: busy right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("core ready again right after accepting a request");

    // a written cell is in bounds and holds a known value
    a_update_known: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && !m_tdata[7]))
        else $error("updated result without in_bounds or with unknown value");

    // the axis unit finishes only while the sequencer waits for it
    a_map_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        map_status.done |-> ((state_reg == ST_MAP_X) || (state_reg == ST_MAP_Y)))
        else $error("axis unit finished outside a mapping state");

    // a merge write is reported in the pending result
    a_write_reported: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPDATE) && merge_write) |=> (res_upd_reg && res_inb_reg))
        else $error("merge write not reflected in result");

    // the sweep ends in idle or with the clear result
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CLEAR) && clr_last) |=>
            ((state_reg == ST_IDLE) || (state_reg == ST_RESULT)))
        else $error("clearing sweep ended in an unexpected state");
`endif

endmodule
